/* hw/rtl/bloom_filter_double_hash_assert.svh */
// Assertion macros shared by the bloom filter RTL.
`ifndef BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BFDH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfdh assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BFDH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfdh assertion failed");

`endif

/* hw/rtl/bfdh_pkg.sv */
// Package: constants, payload types and state type of the bloom filter.
`default_nettype none

package bfdh_pkg;

   localparam int HASH_W      = 64;
   localparam int MAX_BITS    = 65536;
   localparam int MAX_PROBES  = 16;
   localparam int BYTE_W      = 8;
   localparam int SEL_W       = 3;
   localparam int CNT_W       = 17;
   localparam int PROBE_W     = 5;
   localparam int IDX_W       = $clog2(MAX_BITS);
   localparam int BYTE_AW     = IDX_W - SEL_W;
   localparam int STORE_BYTES = MAX_BITS / BYTE_W;
   localparam int PCNT_W      = $clog2(MAX_PROBES + 1);
   localparam int STEP_W      = $clog2(HASH_W);
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic REG_BIT_COUNT   = 1'b0;
   localparam logic REG_PROBE_COUNT = 1'b1;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_TEST   = 1'b1;

   localparam logic [CNT_W-1:0]   BIT_COUNT_RST   = CNT_W'(MAX_BITS);
   localparam logic [PROBE_W-1:0] PROBE_COUNT_RST = PROBE_W'(7);

   typedef struct packed {
      logic              req_type;
      logic [HASH_W-1:0] base_hash;
      logic [HASH_W-1:0] step_hash;
   } req_item_type;

   typedef struct packed {
      logic present;
      logic was_test;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/bloom_filter_double_hash.sv */
// Top level: bloom filter with double-hash probing over an on-chip bit store.
// The block handles one request at a time. After reset it first clears the
// 8192-byte bit store, one byte a cycle, and holds busy high while it does;
// CSR writes are taken as usual meanwhile. A request is taken when start is
// high and busy is low. Each probe runs the 64 steps of the shared restoring
// remainder unit (one bit of the 64-bit probe sum a cycle), then reads the
// store byte and checks or sets the bit. Busy stays high through all probes
// of an item (at most 16) and through its result; a test stops at the first
// clear bit and a probe count of zero goes straight to the result. The result
// shows on rsp_item for exactly one cycle with rsp_valid high; the receiver
// has no way to stall it, so it must take every transfer.
`default_nettype none
`include "bloom_filter_double_hash_assert.svh"

module bloom_filter_double_hash (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  bfdh_pkg::req_item_type        req_item,
   // result channel
   output logic                          rsp_valid,
   output bfdh_pkg::rsp_item_type        rsp_item,
   // CSR port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bfdh_pkg::CSR_AW-1:0]   paddr,
   input  logic [bfdh_pkg::CSR_DW-1:0]   pwdata,
   output logic [bfdh_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import bfdh_pkg::*;

   // CSRs
   logic [CNT_W-1:0]   bit_count_ff, bit_count_in;
   logic [PROBE_W-1:0] probe_count_ff, probe_count_in;
   logic               csr_wr;
   logic [CNT_W-1:0]   eff_bits;
   logic [PCNT_W-1:0]  eff_probes;

   // sequencer state
   state_type          state_ff, state_in;
   logic [BYTE_AW-1:0] clr_ff, clr_in;
   logic               test_ff, test_in;
   logic               present_ff, present_in;
   logic [HASH_W-1:0]  acc_ff, acc_in;
   logic [HASH_W-1:0]  step_ff, step_in;
   logic [HASH_W-1:0]  acc_next;
   logic [CNT_W-1:0]   bits_ff, bits_in;
   logic [PCNT_W-1:0]  probes_ff, probes_in;
   logic [PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [PCNT_W-1:0]  pcnt_inc;
   logic [BYTE_AW-1:0] byte_ff, byte_in;
   logic [SEL_W-1:0]   sel_ff, sel_in;

   // remainder unit
   logic               div_start;
   logic [HASH_W-1:0]  div_dividend;
   logic               div_done;
   logic [IDX_W-1:0]   div_rem;

   // bit store
   logic               ram_we;
   logic [BYTE_AW-1:0] ram_waddr;
   logic [BYTE_W-1:0]  ram_wdata;
   logic [BYTE_AW-1:0] ram_raddr;
   logic [BYTE_W-1:0]  ram_rdata;
   logic               probe_bit;

   // ---------------------------------------------------------------- CSR
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      bit_count_in   = bit_count_ff;
      probe_count_in = probe_count_ff;
      if (csr_wr) begin
         unique case (paddr[CSR_AW-1])
            REG_BIT_COUNT:   bit_count_in   = pwdata[CNT_W-1:0];
            REG_PROBE_COUNT: probe_count_in = pwdata[PROBE_W-1:0];
            default:         bit_count_in   = bit_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff   <= BIT_COUNT_RST;
         probe_count_ff <= PROBE_COUNT_RST;
      end else begin
         bit_count_ff   <= bit_count_in;
         probe_count_ff <= probe_count_in;
      end
   end

   assign prdata = (paddr[CSR_AW-1] == REG_PROBE_COUNT) ? CSR_DW'(probe_count_ff)
                                                         : CSR_DW'(bit_count_ff);

   // Saturate the registers to the legal ranges: a zero bit count acts as one.
   always_comb begin
      priority if (bit_count_ff == '0) begin
         eff_bits = CNT_W'(1);
      end else if (bit_count_ff > CNT_W'(MAX_BITS)) begin
         eff_bits = CNT_W'(MAX_BITS);
      end else begin
         eff_bits = bit_count_ff;
      end
      if (probe_count_ff > PROBE_W'(MAX_PROBES)) begin
         eff_probes = PCNT_W'(MAX_PROBES);
      end else begin
         eff_probes = PCNT_W'(probe_count_ff);
      end
   end

   // ---------------------------------------------------------- sequencer
   assign acc_next  = acc_ff + step_ff;   // next probe sum, wraps mod 2^64
   assign pcnt_inc  = pcnt_ff + 1'b1;
   assign probe_bit = ram_rdata[sel_ff];
   assign ram_raddr = div_rem[IDX_W-1:SEL_W];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      test_in      = test_ff;
      present_in   = present_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      bits_in      = bits_ff;
      probes_in    = probes_ff;
      pcnt_in      = pcnt_ff;
      byte_in      = byte_ff;
      sel_in       = sel_ff;
      div_start    = 1'b0;
      div_dividend = acc_next;
      ram_we       = 1'b0;
      ram_waddr    = byte_ff;
      ram_wdata    = ram_rdata | (BYTE_W'(1) << sel_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the store to zero, one byte a cycle
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               test_in    = req_item.req_type;
               present_in = (req_item.req_type == REQ_TEST);
               acc_in     = req_item.base_hash;
               step_in    = req_item.step_hash;
               bits_in    = eff_bits;
               probes_in  = eff_probes;
               pcnt_in    = '0;
               if (eff_probes == '0) begin
                  state_in = ST_RESP;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = req_item.base_hash;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // remainder ready: issue the byte read, hold the bit position
            if (div_done) begin
               byte_in  = div_rem[IDX_W-1:SEL_W];
               sel_in   = div_rem[SEL_W-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (test_ff && !probe_bit) begin
               // first clear bit ends a test
               present_in = 1'b0;
               state_in   = ST_RESP;
            end else begin
               ram_we  = (test_ff == REQ_INSERT);
               pcnt_in = pcnt_inc;
               acc_in  = acc_next;
               if (pcnt_inc == probes_ff) begin
                  state_in = ST_RESP;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      test_ff    <= test_in;
      present_ff <= present_in;
      acc_ff     <= acc_in;
      step_ff    <= step_in;
      bits_ff    <= bits_in;
      probes_ff  <= probes_in;
      pcnt_ff    <= pcnt_in;
      byte_ff    <= byte_in;
      sel_ff     <= sel_in;
   end

   // --------------------------------------------------------- datapath
   bfdh_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (bits_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   bfdh_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------- outputs
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_item.present  = present_ff;
   assign rsp_item.was_test = test_ff;

   // ------------------------------------------------------- assertions
   `BFDH_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `BFDH_ASSERT_NEXT(a_rsp_single_cycle, clock, reset, rsp_valid, !rsp_valid && !busy)
   `BFDH_ASSERT_IMPL(a_store_write_owner, clock, reset, ram_we, (state_ff == ST_CLEAR) || ((state_ff == ST_CHECK) && !test_ff))
   `BFDH_ASSERT_IMPL(a_probe_in_range, clock, reset, (state_ff == ST_DIV) || (state_ff == ST_CHECK), pcnt_ff < probes_ff)
   `BFDH_ASSERT_IMPL(a_insert_not_present, clock, reset, rsp_valid && !test_ff, !present_ff)

endmodule

`default_nettype wire

/* hw/rtl/bfdh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfdh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/bfdh_mod.sv */
// Iterative remainder unit: 64-bit dividend modulo a 17-bit divisor, one bit a cycle.
`default_nettype none

module bfdh_mod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bfdh_pkg::HASH_W-1:0]  dividend,
   input  logic [bfdh_pkg::CNT_W-1:0]   divisor,
   output logic                         done,
   output logic [bfdh_pkg::IDX_W-1:0]   remainder
);
   import bfdh_pkg::*;

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   always_comb begin
      trial     = {rem_ff, dvd_ff[HASH_W-1]};
      diff      = trial - {1'b0, divisor};
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = STEP_W'(HASH_W - 1);
         dvd_in    = dividend;
         rem_in    = '0;
      end else if (active_ff) begin
         // shift in the next dividend bit, subtract when it fits
         dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[CNT_W-1:0];
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[IDX_W-1:0];

endmodule

`default_nettype wire
